// ----- hw/rtl/u8d_pkg.sv -----
// Shared types, constants and lookup functions for the UTF-8 automaton decoder.
package u8d_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CLASS_W     = 4;
    localparam int unsigned STATE_W     = 4;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CODE_W      = 21;
    localparam int unsigned STATE_COUNT = 9;
    localparam int unsigned CLASS_COUNT = 12;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;

    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MORE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3f;
    localparam logic [BYTE_W-1:0] LEAD_MASK = 8'hff;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              restart;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   codepoint;
    } t_out_item;

    // classified byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]  byte_in;
        logic               restart;
        logic [CLASS_W-1:0] cls;
    } t_cls_item;

    localparam logic [STATE_W-1:0] NEXT_STATE_TBL [STATE_COUNT][CLASS_COUNT] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] c;
        priority if (b <= 8'h7f) c = 4'd0;
        else if (b <= 8'h8f)     c = 4'd1;
        else if (b <= 8'h9f)     c = 4'd9;
        else if (b <= 8'hbf)     c = 4'd7;
        else if (b <= 8'hc1)     c = 4'd8;
        else if (b <= 8'hdf)     c = 4'd2;
        else if (b == 8'he0)     c = 4'd10;
        else if (b == 8'hed)     c = 4'd4;
        else if (b <= 8'hef)     c = 4'd3;
        else if (b == 8'hf0)     c = 4'd11;
        else if (b <= 8'hf3)     c = 4'd6;
        else if (b == 8'hf4)     c = 4'd5;
        else                     c = 4'd8;
        return c;
    endfunction

    function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] st,
                                                      input logic [CLASS_W-1:0] cls);
        logic [STATE_W-1:0] ns;
        if (st >= STATE_W'(STATE_COUNT) || cls >= CLASS_W'(CLASS_COUNT)) begin
            ns = ST_REJECT;
        end else begin
            ns = NEXT_STATE_TBL[st][cls];
        end
        return ns;
    endfunction

endpackage

// ----- hw/rtl/u8d_front.sv -----
// Front stage: takes input bytes, looks up the character class, registers the result.
module u8d_front import u8d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_push,
    input  logic      i_push_ready,
    output t_cls_item o_push_item
);

    logic      r_valid;
    t_cls_item r_item;

    assign o_in_ready  = !r_valid || i_push_ready;
    assign o_push      = r_valid;
    assign o_push_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.byte_in <= i_in_item.byte_in;
            r_item.restart <= i_in_item.restart;
            r_item.cls     <= byte_class(i_in_item.byte_in);
        end
    end

endmodule

// ----- hw/rtl/u8d_queue.sv -----
// Small FIFO of classified bytes between the front and back stages.
module u8d_queue import u8d_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_push_ready,
    input  t_cls_item i_push_item,
    output logic      o_pop_valid,
    input  logic      i_pop,
    output t_cls_item o_pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_cls_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- hw/rtl/u8d_back.sv -----
// Back stage: automaton state and accumulator update, registered result.
module u8d_back import u8d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_valid,
    output logic      o_pop,
    input  t_cls_item i_pop_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic [STATE_W-1:0] r_state, n_state;
    logic [CODE_W-1:0]  r_acc, n_acc;
    logic               r_out_valid;
    t_out_item          r_out_item;
    logic [STATE_W-1:0] cur_state;
    logic [BYTE_W-1:0]  lead_bits;
    logic [STATUS_W-1:0] n_status;

    assign o_pop       = i_pop_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        cur_state = i_pop_item.restart ? ST_ACCEPT : r_state;
        // lead byte payload: the class doubles as the mask shift
        lead_bits = (LEAD_MASK >> i_pop_item.cls) & i_pop_item.byte_in;
        if (cur_state != ST_ACCEPT) begin
            n_acc = {r_acc[CODE_W-7:0], i_pop_item.byte_in[5:0] & CONT_MASK[5:0]};
        end else begin
            n_acc = CODE_W'(lead_bits);
        end
        n_state = next_state(cur_state, i_pop_item.cls);
        priority if (n_state == ST_ACCEPT) n_status = STATUS_COMPLETE;
        else if (n_state == ST_REJECT)     n_status = STATUS_REJECTED;
        else                               n_status = STATUS_MORE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state <= n_state;
                r_acc   <= n_acc;
            end
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= i_pop_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item.status    <= n_status;
            r_out_item.codepoint <= n_acc;
        end
    end

endmodule

// ----- hw/rtl/utf8_dfa_decoder_unit.sv -----
// Top level of the UTF-8 automaton decoder: front stage, queue and back stage.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_ready   i_in_item  (byte_in, restart)
//   output   out        o_out_valid / i_out_ready o_out_item (status, codepoint)
//
// One byte per cycle sustained while the output accepts results; each result passes the
// class register, the queue and the result register before it can transfer out.
// Reset is synchronous: automaton goes to accept, accumulator to zero, all stages empty.
// The queue lets the front keep taking bytes while the output stalls, until it fills.
module utf8_dfa_decoder_unit import u8d_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      push, push_ready, pop_valid, pop;
    t_cls_item push_item, pop_item;

    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    u8d_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_item   (pop_item)
    );

    u8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop       (pop),
        .i_pop_item  (pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
